[rtl/ofcc_pkg.sv]
package ofcc_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int WHEEL_SIZE = 55;
    localparam int ANG_BITS   = 20;
    localparam int ANG_ITER   = 16;
    localparam int PRE_SHIFT  = 24;

    localparam int SEG_RY = 15;
    localparam int SEG_YG = 6;
    localparam int SEG_GC = 4;
    localparam int SEG_CB = 11;
    localparam int SEG_BM = 13;
    localparam int SEG_MR = 6;

    // one word queued between the front and the back
    typedef struct packed {
        logic        req_type;
        logic        frame_start;
        logic [31:0] flow_x;
        logic [31:0] flow_y;
        logic        unknown;
    } item_t;

    typedef logic [23:0] wheel_tab_t [WHEEL_SIZE];

    function automatic wheel_tab_t make_wheel();
        wheel_tab_t tab;
        int k;
        int r;
        int g;
        int b;
        for (int i = 0; i < WHEEL_SIZE; i++) begin
            k = i;
            if (k < SEG_RY) begin
                r = 255; g = 255 * k / SEG_RY; b = 0;
            end else if (k < SEG_RY + SEG_YG) begin
                k = k - SEG_RY;
                r = 255 - 255 * k / SEG_YG; g = 255; b = 0;
            end else if (k < SEG_RY + SEG_YG + SEG_GC) begin
                k = k - SEG_RY - SEG_YG;
                r = 0; g = 255; b = 255 * k / SEG_GC;
            end else if (k < SEG_RY + SEG_YG + SEG_GC + SEG_CB) begin
                k = k - SEG_RY - SEG_YG - SEG_GC;
                r = 0; g = 255 - 255 * k / SEG_CB; b = 255;
            end else if (k < SEG_RY + SEG_YG + SEG_GC + SEG_CB + SEG_BM) begin
                k = k - SEG_RY - SEG_YG - SEG_GC - SEG_CB;
                r = 255 * k / SEG_BM; g = 0; b = 255;
            end else begin
                k = k - SEG_RY - SEG_YG - SEG_GC - SEG_CB - SEG_BM;
                if (k >= SEG_MR) k = SEG_MR - 1;
                r = 255; g = 0; b = 255 - 255 * k / SEG_MR;
            end
            tab[i] = {8'(r), 8'(g), 8'(b)};
        end
        return tab;
    endfunction

    localparam wheel_tab_t WHEEL = make_wheel();

    function automatic logic [17:0] atan_step(input logic [3:0] i);
        logic [17:0] a;
        case (i)
            4'd0:    a = 18'd131072;
            4'd1:    a = 18'd77376;
            4'd2:    a = 18'd40884;
            4'd3:    a = 18'd20753;
            4'd4:    a = 18'd10417;
            4'd5:    a = 18'd5213;
            4'd6:    a = 18'd2607;
            4'd7:    a = 18'd1304;
            4'd8:    a = 18'd652;
            4'd9:    a = 18'd326;
            4'd10:   a = 18'd163;
            4'd11:   a = 18'd81;
            4'd12:   a = 18'd41;
            4'd13:   a = 18'd20;
            4'd14:   a = 18'd10;
            default: a = 18'd5;
        endcase
        return a;
    endfunction

endpackage

[rtl/optical_flow_color_coder.sv]
// Flow color coder: stream a frame twice, measure words (req_type 0) first to
// find the peak vector length, then color words (req_type 1), each giving one
// RGB pixel on the output channel; measure words give none. A two-word queue
// parts the input from the arithmetic. A known vector runs through S_SQA and
// S_SQB (squaring) and a 32-step square root (the CORDIC angle runs alongside);
// a color word then takes a FRAC_BITS+1 step divide by the peak unless longer,
// then S_MIX, S_SCALE and S_EMIT for color mixing and output. Unknown words
// and zero-peak pixels skip the arithmetic. Write unknown_limit only while idle.
module optical_flow_color_coder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [30:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic        s_frame_start,
    input  logic [31:0] s_flow_x,
    input  logic [31:0] s_flow_y,
    input  logic        s_flow_nan,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_red,
    output logic [7:0]  m_green,
    output logic [7:0]  m_blue,
    output logic        m_pixel_unknown
);

    logic [30:0] limit_reg;
    logic        q_valid;
    logic        q_ready;
    ofcc_pkg::item_t q_item;

    always_ff @(posedge aclk) begin
        if (!aresetn)       limit_reg <= 31'h7FFF_FFFF;
        else if (cfg_wr_en) limit_reg <= cfg_wr_data;
    end

    ofcc_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .unknown_limit (limit_reg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_frame_start (s_frame_start),
        .s_flow_x      (s_flow_x),
        .s_flow_y      (s_flow_y),
        .s_flow_nan    (s_flow_nan),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_item        (q_item)
    );

    ofcc_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_valid),
        .q_ready         (q_ready),
        .q_item          (q_item),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_red           (m_red),
        .m_green         (m_green),
        .m_blue          (m_blue),
        .m_pixel_unknown (m_pixel_unknown)
    );

endmodule

[rtl/ofcc_front.sv]
module ofcc_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [30:0]          unknown_limit,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_req_type,
    input  logic                 s_frame_start,
    input  logic [31:0]          s_flow_x,
    input  logic [31:0]          s_flow_y,
    input  logic                 s_flow_nan,
    output logic                 q_valid,
    input  logic                 q_ready,
    output ofcc_pkg::item_t      q_item
);

    ofcc_pkg::item_t mem_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] count_reg;
    logic [31:0] mag_x;
    logic [31:0] mag_y;
    ofcc_pkg::item_t in_item;
    logic push;
    logic pop;

    assign mag_x = s_flow_x[31] ? (~s_flow_x + 32'd1) : s_flow_x;
    assign mag_y = s_flow_y[31] ? (~s_flow_y + 32'd1) : s_flow_y;

    always_comb begin
        in_item.req_type    = s_req_type;
        in_item.frame_start = s_frame_start;
        in_item.flow_x      = s_flow_x;
        in_item.flow_y      = s_flow_y;
        in_item.unknown     = s_flow_nan || (mag_x > {1'b0, unknown_limit})
                              || (mag_y > {1'b0, unknown_limit});
    end

    assign s_ready = (count_reg != 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = mem_reg[rptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wptr_reg] <= in_item;
        if (!aresetn) begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            if (push) wptr_reg <= ~wptr_reg;
            if (pop)  rptr_reg <= ~rptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

[rtl/ofcc_back.sv]
module ofcc_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  ofcc_pkg::item_t      q_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [7:0]           m_red,
    output logic [7:0]           m_green,
    output logic [7:0]           m_blue,
    output logic                 m_pixel_unknown
);

    localparam int FB  = ofcc_pkg::FRAC_BITS;
    localparam int AB  = ofcc_pkg::ANG_BITS;
    localparam int FW  = AB + FB;
    localparam int CW  = FB + 9;
    localparam logic [FB:0]   ONE   = (FB + 1)'(1) << FB;
    localparam logic [CW-1:0] WHITE = CW'(255) << FB;

    typedef enum logic [2:0] {
        S_IDLE, S_SQA, S_SQB, S_ROOT, S_DIV, S_MIX, S_SCALE, S_EMIT
    } state_t;

    state_t state_reg;
    ofcc_pkg::item_t it_reg;
    logic [31:0] ax_reg, ay_reg;
    logic [63:0] sum_reg;
    logic [34:0] rem_reg;
    logic [31:0] root_reg;
    logic [5:0]  cnt_reg;
    logic signed [59:0] cx_reg, cy_reg;
    logic signed [21:0] cz_reg;
    logic [4:0]  ccnt_reg;
    logic        cbase_reg;
    logic        cskip_reg;
    logic [32:0] peak_reg;
    logic [34:0] drem_reg;
    logic [FB:0] q_reg;
    logic        dim_reg;
    logic [CW-1:0] c_reg [3];
    logic [7:0]  pix_reg [3];
    logic        pixunk_reg;
    logic        mv_reg;
    logic [7:0]  mr_reg, mg_reg, mb_reg;
    logic        mu_reg;

    logic [31:0] fx_mag, fy_mag;
    logic signed [59:0] fx_s, fy_s;
    logic [34:0] rem_sh, trial;
    logic        root_ge;
    logic [32:0] peak_base;
    logic        div_ge;
    logic [34:0] drem_sub;
    logic signed [59:0] sh_x, sh_y;
    logic signed [21:0] atan_s;
    logic [AB-1:0] t_ang;
    logic [25:0] fk;
    logic [5:0]  k0, k1;
    logic [FW-1:0] fwide;
    logic [FB-1:0] f;
    logic [23:0] w0, w1;
    logic [CW-1:0] c_mix [3];
    logic [7:0]  res [3];
    logic        out_free;

    assign fx_mag = q_item.flow_x[31] ? (~q_item.flow_x + 32'd1) : q_item.flow_x;
    assign fy_mag = q_item.flow_y[31] ? (~q_item.flow_y + 32'd1) : q_item.flow_y;
    assign fx_s   = 60'(signed'(q_item.flow_x)) <<< ofcc_pkg::PRE_SHIFT;
    assign fy_s   = 60'(signed'(q_item.flow_y)) <<< ofcc_pkg::PRE_SHIFT;

    assign rem_sh  = {rem_reg[32:0], sum_reg[63:62]};
    assign trial   = {1'b0, root_reg, 2'b01};
    assign root_ge = (rem_sh >= trial);
    assign peak_base = it_reg.frame_start ? 33'd0 : peak_reg;

    assign div_ge   = (drem_reg >= {2'b00, peak_reg});
    assign drem_sub = div_ge ? (drem_reg - {2'b00, peak_reg}) : drem_reg;

    assign sh_x   = cx_reg >>> ccnt_reg[3:0];
    assign sh_y   = cy_reg >>> ccnt_reg[3:0];
    assign atan_s = signed'({4'b0000, ofcc_pkg::atan_step(ccnt_reg[3:0])});

    always_comb begin
        t_ang = AB'(({21'd0, cbase_reg} << (AB - 1)) + 22'(cz_reg));
        fk    = 26'(t_ang) * 26'(ofcc_pkg::WHEEL_SIZE - 1);
        k0    = fk[25:20];
        k1    = (k0 == 6'(ofcc_pkg::WHEEL_SIZE - 1)) ? 6'd0 : k0 + 6'd1;
        fwide = FW'(fk[AB-1:0]) << FB;
        f     = fwide[FW-1:AB];
        w0    = ofcc_pkg::WHEEL[k0];
        w1    = ofcc_pkg::WHEEL[k1];
        for (int ch = 0; ch < 3; ch++) begin
            c_mix[ch] = CW'((ONE - {1'b0, f}) * w0[23 - 8*ch -: 8])
                      + CW'({1'b0, f} * w1[23 - 8*ch -: 8]);
        end
    end

    always_comb begin
        logic [CW-1:0]     diff;
        logic [CW+FB:0]    prod;
        logic [CW-1:0]     wres;
        logic [CW+1:0]     dres;
        for (int ch = 0; ch < 3; ch++) begin
            diff = WHITE - c_reg[ch];
            prod = (CW + FB + 1)'(q_reg) * (CW + FB + 1)'(diff);
            wres = WHITE - CW'(prod >> FB);
            dres = ((CW + 2)'(c_reg[ch]) * (CW + 2)'(3)) >> 2;
            if (dim_reg) res[ch] = 8'(dres >> FB);
            else         res[ch] = (wres >> FB) > CW'(255) ? 8'd255 : 8'(wres >> FB);
        end
    end

    assign out_free = !mv_reg || m_ready;
    assign q_ready  = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                it_reg    <= q_item;
                ax_reg    <= fx_mag;
                ay_reg    <= fy_mag;
                cx_reg    <= q_item.flow_x[31] ? -fx_s : fx_s;
                cy_reg    <= q_item.flow_x[31] ? -fy_s : fy_s;
                cz_reg    <= '0;
                cbase_reg <= q_item.flow_x[31];
                cskip_reg <= (q_item.flow_y == 32'd0);
                ccnt_reg  <= '0;
            end
            S_SQA: sum_reg <= ax_reg * ax_reg;
            S_SQB: begin
                sum_reg  <= sum_reg + ay_reg * ay_reg;
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= '0;
            end
            S_ROOT: begin
                sum_reg <= sum_reg << 2;
                cnt_reg <= cnt_reg + 6'd1;
                if (root_ge) begin
                    rem_reg  <= rem_sh - trial;
                    root_reg <= {root_reg[30:0], 1'b1};
                end else begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[30:0], 1'b0};
                end
            end
            S_DIV: begin
                drem_reg <= drem_sub << 1;
                q_reg    <= {q_reg[FB-1:0], div_ge};
                cnt_reg  <= cnt_reg + 6'd1;
            end
            S_MIX: for (int ch = 0; ch < 3; ch++) c_reg[ch] <= c_mix[ch];
            S_SCALE: for (int ch = 0; ch < 3; ch++) pix_reg[ch] <= res[ch];
            default: ;
        endcase
        // rotate toward the x axis while the root runs
        if (state_reg == S_ROOT && ccnt_reg != 5'(ofcc_pkg::ANG_ITER)) begin
            ccnt_reg <= ccnt_reg + 5'd1;
            if (!cskip_reg) begin
                if (!cy_reg[59]) begin
                    cx_reg <= cx_reg + sh_y;
                    cy_reg <= cy_reg - sh_x;
                    cz_reg <= cz_reg + atan_s;
                end else begin
                    cx_reg <= cx_reg - sh_y;
                    cy_reg <= cy_reg + sh_x;
                    cz_reg <= cz_reg - atan_s;
                end
            end
        end
        if (state_reg == S_ROOT && cnt_reg == 6'd31) begin
            drem_reg <= 35'(root_reg[30:0]) << 1 | 35'(root_ge);
            dim_reg  <= ({root_reg[30:0], root_ge} > peak_reg);
        end
        if (state_reg == S_IDLE && q_valid) begin
            pixunk_reg <= q_item.unknown;
            for (int ch = 0; ch < 3; ch++)
                pix_reg[ch] <= q_item.unknown ? 8'd0 : 8'd255;
        end
        if (state_reg == S_EMIT && out_free) begin
            mr_reg <= pix_reg[0];
            mg_reg <= pix_reg[1];
            mb_reg <= pix_reg[2];
            mu_reg <= pixunk_reg;
        end

        if (!aresetn) begin
            state_reg <= S_IDLE;
            peak_reg  <= '0;
            mv_reg    <= 1'b0;
        end else begin
            if (state_reg == S_EMIT && out_free) mv_reg <= 1'b1;
            else if (m_ready)                    mv_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        if (!q_item.req_type) begin
                            if (q_item.unknown) begin
                                if (q_item.frame_start) peak_reg <= '0;
                            end else begin
                                state_reg <= S_SQA;
                            end
                        end else if (q_item.unknown || peak_reg == 33'd0) begin
                            state_reg <= S_EMIT;
                        end else begin
                            state_reg <= S_SQA;
                        end
                    end
                end
                S_SQA: state_reg <= S_SQB;
                S_SQB: state_reg <= S_ROOT;
                S_ROOT: begin
                    if (cnt_reg == 6'd31) begin
                        if (!it_reg.req_type) begin
                            // drop shorter vectors, keep the peak
                            if ({1'b0, root_reg[30:0], root_ge} > peak_base)
                                peak_reg <= {1'b0, root_reg[30:0], root_ge};
                            else
                                peak_reg <= peak_base;
                            state_reg <= S_IDLE;
                        end else if ({root_reg[30:0], root_ge} > peak_reg) begin
                            state_reg <= S_MIX;
                        end else begin
                            state_reg <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (cnt_reg == 6'(31 + FB + 1)) state_reg <= S_MIX;
                end
                S_MIX:   state_reg <= S_SCALE;
                S_SCALE: state_reg <= S_EMIT;
                S_EMIT: begin
                    if (out_free) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid         = mv_reg;
    assign m_red           = mr_reg;
    assign m_green         = mg_reg;
    assign m_blue          = mb_reg;
    assign m_pixel_unknown = mu_reg;

endmodule

[bench/optical_flow_color_coder_tb.sv]
module optical_flow_color_coder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE = 100;

    typedef struct {
        bit        req_type;
        bit        frame_start;
        bit [31:0] flow_x;
        bit [31:0] flow_y;
        bit        flow_nan;
    } flow_word_t;

    typedef struct {
        bit [7:0] red;
        bit [7:0] green;
        bit [7:0] blue;
        bit       unknown;
    } pixel_t;

    typedef enum bit {MEASURE = 1'b0, COLOR = 1'b1} word_kind_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [30:0] cfg_wr_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_req_type = 1'b0;
    logic        s_frame_start = 1'b0;
    logic [31:0] s_flow_x = '0;
    logic [31:0] s_flow_y = '0;
    logic        s_flow_nan = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_red;
    logic [7:0]  m_green;
    logic [7:0]  m_blue;
    logic        m_pixel_unknown;

    flow_word_t pending_words[$];
    pixel_t     pixels_due[$];
    bit [30:0]  limit_now = 31'h7FFF_FFFF;
    bit [32:0]  peak_now = '0;
    bit         calm_in = 1'b0;
    bit         calm_out = 1'b0;
    int         in_gap = 0;
    int         out_stall = 0;
    int         errors = 0;
    int         cycles = 0;

    optical_flow_color_coder dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_req_type(s_req_type), .s_frame_start(s_frame_start),
        .s_flow_x(s_flow_x), .s_flow_y(s_flow_y), .s_flow_nan(s_flow_nan),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_red(m_red), .m_green(m_green), .m_blue(m_blue),
        .m_pixel_unknown(m_pixel_unknown)
    );

    always #5 aclk = ~aclk;

    // ---------------- predictor ----------------
    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned root = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= root + b) begin
                n = n - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    function automatic longint unsigned abs64(longint signed v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint unsigned vec_length(longint signed x, longint signed y);
        longint unsigned ax = abs64(x);
        longint unsigned ay = abs64(y);
        return root_floor(ax * ax + ay * ay);
    endfunction

    // heading in 2^-20 turn, CORDIC with rounded atan table
    function automatic bit [19:0] heading(longint signed fx, longint signed fy);
        longint signed steps[16] = '{131072, 77376, 40884, 20753, 10417, 5213, 2607, 1304,
                                     652, 326, 163, 81, 41, 20, 10, 5};
        longint signed x = fx <<< 24;
        longint signed y = fy <<< 24;
        longint signed z = 0;
        longint signed base = 0;
        longint signed dx;
        longint signed dy;
        if (x < 0) begin
            x = -x; y = -y; base = 64'd1 << 19;
        end
        if (y != 0) begin
            for (int i = 0; i < 16; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0) begin
                    x = x + dx; y = y - dy; z = z + steps[i];
                end else begin
                    x = x - dx; y = y + dy; z = z - steps[i];
                end
            end
        end
        return 20'(base + z);
    endfunction

    function automatic void wheel_rgb(int k, output longint unsigned rgb[3]);
        if (k < 15) begin
            rgb = '{255, 255 * k / 15, 0};
        end else if (k < 21) begin
            rgb = '{255 - 255 * (k - 15) / 6, 255, 0};
        end else if (k < 25) begin
            rgb = '{0, 255, 255 * (k - 21) / 4};
        end else if (k < 36) begin
            rgb = '{0, 255 - 255 * (k - 25) / 11, 255};
        end else if (k < 49) begin
            rgb = '{255 * (k - 36) / 13, 0, 255};
        end else begin
            rgb = '{255, 0, 255 - 255 * ((k - 49 > 5) ? 5 : k - 49) / 6};
        end
    endfunction

    function automatic void code_pixel(flow_word_t w);
        longint signed fx = longint'($signed(w.flow_x));
        longint signed fy = longint'($signed(w.flow_y));
        longint unsigned one = 64'd1 << ofcc_pkg::FRAC_BITS;
        longint unsigned len;
        longint unsigned fk;
        longint unsigned f;
        longint unsigned c;
        longint unsigned r;
        longint unsigned res;
        longint unsigned w0[3];
        longint unsigned w1[3];
        longint unsigned chan[3];
        int k0;
        bit unknown;
        pixel_t p;
        unknown = w.flow_nan || abs64(fx) > limit_now || abs64(fy) > limit_now;
        if (w.req_type == MEASURE) begin
            if (w.frame_start) peak_now = '0;
            if (!unknown) begin
                len = vec_length(fx, fy);
                if (len > peak_now) peak_now = 33'(len);
            end
            return;
        end
        if (unknown) begin
            p = '{8'd0, 8'd0, 8'd0, 1'b1};
        end else if (peak_now == 0) begin
            p = '{8'd255, 8'd255, 8'd255, 1'b0};
        end else begin
            len = vec_length(fx, fy);
            fk = longint'(heading(fx, fy)) * (ofcc_pkg::WHEEL_SIZE - 1);
            k0 = int'(fk >> ofcc_pkg::ANG_BITS);
            f = ((fk & ((64'd1 << ofcc_pkg::ANG_BITS) - 1)) << ofcc_pkg::FRAC_BITS)
                >> ofcc_pkg::ANG_BITS;
            wheel_rgb(k0, w0);
            wheel_rgb((k0 + 1) % ofcc_pkg::WHEEL_SIZE, w1);
            for (int ch = 0; ch < 3; ch++) begin
                c = (one - f) * w0[ch] + f * w1[ch];
                if (len <= peak_now) begin
                    r = (len << ofcc_pkg::FRAC_BITS) / peak_now;
                    res = 255 * one - ((r * (255 * one - c)) >> ofcc_pkg::FRAC_BITS);
                end else begin
                    res = (c * 3) >> 2;
                end
                res = res >> ofcc_pkg::FRAC_BITS;
                chan[ch] = (res > 255) ? 255 : res;
            end
            p = '{8'(chan[0]), 8'(chan[1]), 8'(chan[2]), 1'b0};
        end
        pixels_due.push_back(p);
    endfunction

    // ---------------- idling ----------------
    function automatic int pick_gap(bit calm);
        int roll = $urandom_range(0, 99);
        if (calm || roll < 55) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ---------------- driver ----------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                code_pixel(pending_words.pop_front());
            end
            if (!(s_valid && !s_ready)) begin
                if (in_gap > 0) begin
                    in_gap--;
                    s_valid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    s_valid       <= 1'b1;
                    s_req_type    <= pending_words[0].req_type;
                    s_frame_start <= pending_words[0].frame_start;
                    s_flow_x      <= pending_words[0].flow_x;
                    s_flow_y      <= pending_words[0].flow_y;
                    s_flow_nan    <= pending_words[0].flow_nan;
                    if ($urandom_range(0, 149) == 0) calm_in = !calm_in;
                    in_gap = pick_gap(calm_in);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------
    always @(posedge aclk) begin
        pixel_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pixels_due.size() == 0) begin
                    $display("%0t: unexpected pixel r=%0d g=%0d b=%0d unk=%0b", $time,
                             m_red, m_green, m_blue, m_pixel_unknown);
                    errors++;
                end else begin
                    want = pixels_due.pop_front();
                    if (m_red !== want.red || m_green !== want.green ||
                        m_blue !== want.blue || m_pixel_unknown !== want.unknown) begin
                        $display("%0t: exp r=%0d g=%0d b=%0d u=%0b, got r=%0d g=%0d b=%0d u=%0b",
                                 $time, want.red, want.green, want.blue, want.unknown,
                                 m_red, m_green, m_blue, m_pixel_unknown);
                        errors++;
                    end
                end
            end
            if (out_stall > 0) begin
                out_stall--;
                m_ready <= 1'b0;
            end else begin
                if ($urandom_range(0, 99) == 0) calm_out = !calm_out;
                out_stall = pick_gap(calm_out);
                m_ready <= (out_stall == 0);
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    function automatic void add_word(bit kind, bit start, bit [31:0] x, bit [31:0] y, bit nan);
        flow_word_t w;
        w = '{kind, start, x, y, nan};
        pending_words.push_back(w);
    endfunction

    function automatic bit [31:0] rand_comp();
        int roll = $urandom_range(0, 19);
        if (roll == 0) return 32'h0;
        if (roll == 1) return 32'h8000_0000;
        if (roll == 2) return 32'h7FFF_FFFF;
        if (roll < 6) return $urandom;
        return 32'($signed($urandom) >>> $urandom_range(8, 31));
    endfunction

    // measure pass then color pass over the same vectors, with some noise
    function automatic void add_frame();
        bit [31:0] xs[$];
        bit [31:0] ys[$];
        bit        ns[$];
        int n = $urandom_range(1, 10);
        for (int i = 0; i < n; i++) begin
            xs.push_back(rand_comp());
            ys.push_back(rand_comp());
            ns.push_back($urandom_range(0, 19) == 0);
            add_word(MEASURE, i == 0 || $urandom_range(0, 29) == 0, xs[i], ys[i], ns[i]);
        end
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0)
                add_word(COLOR, 1'($urandom_range(0, 1)), rand_comp(), rand_comp(),
                         $urandom_range(0, 9) == 0);
            add_word(COLOR, $urandom_range(0, 9) == 0, xs[i], ys[i], ns[i]);
        end
    endfunction

    // hold off until every queued word is sent and every pixel is back
    task automatic drain_and_idle();
        wait (pending_words.size() == 0 && !s_valid && pixels_due.size() == 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_limit(bit [30:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        limit_now = value;
    endtask

    initial begin
        bit [30:0] limits[5];
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // zero peak gives white, unknown gives black
        add_word(COLOR, 1'b0, 32'h0001_0000, 32'h0002_0000, 1'b0);
        add_word(COLOR, 1'b0, 32'h0001_0000, 32'h0, 1'b1);
        add_word(COLOR, 1'b0, 32'h8000_0000, 32'h0, 1'b0);
        add_word(MEASURE, 1'b1, 32'h0003_0000, 32'h0004_0000, 1'b0);
        add_word(MEASURE, 1'b0, 32'h7FFF_FFFF, 32'h0, 1'b1);
        add_word(MEASURE, 1'b0, 32'h8000_0000, 32'h0, 1'b0);
        add_word(COLOR, 1'b0, 32'h0, 32'h0, 1'b0);
        add_word(COLOR, 1'b0, 32'h0003_0000, 32'h0004_0000, 1'b0);
        add_word(COLOR, 1'b1, 32'h0005_0000, 32'h0, 1'b0);
        add_word(COLOR, 1'b0, 32'hFFFB_0000, 32'h0, 1'b0);
        add_word(COLOR, 1'b0, 32'h0, 32'h0005_0000, 1'b0);
        add_word(COLOR, 1'b0, 32'h0, 32'hFFFB_0000, 1'b0);
        add_word(COLOR, 1'b0, 32'hFFFD_0000, 32'hFFFC_0000, 1'b0);
        add_word(COLOR, 1'b0, 32'h0030_0000, 32'hFFC0_0000, 1'b0);
        add_word(MEASURE, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        add_word(COLOR, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        add_word(COLOR, 1'b0, 32'h8000_0001, 32'h7FFF_FFFF, 1'b0);
        add_word(COLOR, 1'b0, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0);
        add_word(MEASURE, 1'b1, 32'h0, 32'h0, 1'b0);
        add_word(COLOR, 1'b0, 32'h0, 32'h0, 1'b0);
        drain_and_idle();

        limits = '{31'h0, 31'h0001_0000, 31'($urandom), 31'h7FFF_FFFE, 31'h7FFF_FFFF};
        foreach (limits[p]) begin
            write_limit(limits[p]);
            if (limits[p] == 0) begin
                add_word(MEASURE, 1'b1, 32'h0, 32'h0, 1'b0);
                add_word(COLOR, 1'b0, 32'h0, 32'h0, 1'b0);
                add_word(COLOR, 1'b0, 32'h0, 32'h1, 1'b0);
            end
            while (pending_words.size() < 200) add_frame();
            drain_and_idle();
        end

        if (errors == 0 && pixels_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

[filelist.f]
rtl/ofcc_pkg.sv
rtl/ofcc_front.sv
rtl/ofcc_back.sv
rtl/optical_flow_color_coder.sv
bench/optical_flow_color_coder_tb.sv
